@@ sv/rrse_pkg.sv @@
// ----------------------------------------------------------------------------
// rrse_pkg
// Shared types and constants for the row run segment extractor.
// ----------------------------------------------------------------------------
package rrse_pkg;

  // Field widths
  localparam int K_W     = 8;
  localparam int GEO_W   = 13;
  localparam int LINE_W  = 12;
  localparam int START_W = 12;
  localparam int END_W   = 13;

  // Default geometry limits
  localparam int MAX_LINE_LENGTH_DEF = 4096;
  localparam int MAX_LINES_DEF       = 4096;

  // Smallest usable line length and line count
  localparam logic [GEO_W-1:0] GEO_MIN = GEO_W'(2);

  // Register reset values
  localparam logic [K_W-1:0]   OPEN_HALF_WIDTH_RST = K_W'(2);
  localparam logic [GEO_W-1:0] MERGE_GAP_LIMIT_RST = GEO_W'(10);
  localparam logic [GEO_W-1:0] LINE_LENGTH_RST     = GEO_W'(640);
  localparam logic [GEO_W-1:0] LINE_COUNT_RST      = GEO_W'(480);

  // Result queue
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OPEN_HALF_WIDTH = 2'd0,
    REG_MERGE_GAP_LIMIT = 2'd1,
    REG_LINE_LENGTH     = 2'd2,
    REG_LINE_COUNT      = 2'd3
  } reg_index_t;

  typedef struct packed {
    logic [K_W-1:0]   open_half_width;
    logic [GEO_W-1:0] merge_gap_limit;
    logic [GEO_W-1:0] line_length;
    logic [GEO_W-1:0] line_count;
  } cfg_t;

  typedef struct packed {
    logic [LINE_W-1:0]  line_index;
    logic [START_W-1:0] seg_start;
    logic [END_W-1:0]   seg_end;
    logic               last;
  } result_t;

  // Up to two results per pixel; first is always filled before second
  typedef struct packed {
    logic    valid0;
    logic    valid1;
    result_t r0;
    result_t r1;
  } push_t;

endpackage

@@ sv/rrse_core.sv @@
// ----------------------------------------------------------------------------
// rrse_core
// Pixel register, run tracking, opening filter, gap merge and line flush.
// ----------------------------------------------------------------------------
module rrse_core #(
  parameter int MAX_LINE_LENGTH = rrse_pkg::MAX_LINE_LENGTH_DEF,
  parameter int MAX_LINES       = rrse_pkg::MAX_LINES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  rrse_pkg::cfg_t        cfg,
  input  logic                  in_valid,
  input  logic                  edge_bit,
  output logic                  in_stall,
  input  logic                  room,
  output rrse_pkg::push_t       push
);

  localparam int GW = rrse_pkg::GEO_W;
  localparam int GMAX = (1 << GW) - 1;
  localparam logic [GW-1:0] LEN_HI =
    (MAX_LINE_LENGTH > GMAX) ? GW'(GMAX) : GW'(MAX_LINE_LENGTH);
  localparam logic [GW-1:0] CNT_HI =
    (MAX_LINES > GMAX) ? GW'(GMAX) : GW'(MAX_LINES);

  // Pixel register
  logic px_valid;
  logic px_bit;

  // Line state
  logic [GW-1:0]                 column_count, column_count_next;
  logic [rrse_pkg::LINE_W-1:0]   line_counter, line_counter_next;
  logic                          in_run, in_run_next;
  logic [GW-1:0]                 run_begin, run_begin_next;
  logic                          pending_valid, pending_valid_next;
  logic [GW-1:0]                 pending_start, pending_start_next;
  logic [GW-1:0]                 pending_end, pending_end_next;

  logic          process;
  logic [GW-1:0] len_u, cnt_u;
  logic          last_line, forced, eol;
  logic          close, at_left, at_right, keep, merge;
  logic [GW-1:0] rb, re, rlen, gap;
  logic [GW-1:0] k1, k2;
  logic          emit_a, emit_b;
  logic          pv2;
  logic [GW-1:0] ps2, pe2;
  rrse_pkg::result_t res_a, res_b;

  assign process  = px_valid && room;
  assign in_stall = px_valid && !room;

  always_comb begin
    if (cfg.line_length < rrse_pkg::GEO_MIN) begin
      len_u = rrse_pkg::GEO_MIN;
    end else if (cfg.line_length > LEN_HI) begin
      len_u = LEN_HI;
    end else begin
      len_u = cfg.line_length;
    end
    if (cfg.line_count < rrse_pkg::GEO_MIN) begin
      cnt_u = rrse_pkg::GEO_MIN;
    end else if (cfg.line_count > CNT_HI) begin
      cnt_u = CNT_HI;
    end else begin
      cnt_u = cfg.line_count;
    end
  end

  assign last_line = {1'b0, line_counter} >= (cnt_u - GW'(1));
  assign forced    = (line_counter == '0) || last_line;
  assign eol       = column_count >= (len_u - GW'(1));

  // A run closes on a falling edge, or at line end while the pixel is set
  assign close    = (in_run && !px_bit) || (eol && px_bit);
  assign rb       = in_run ? run_begin : column_count;
  assign re       = px_bit ? (column_count + GW'(1)) : column_count;
  assign at_right = px_bit;
  assign at_left  = (rb == '0);
  assign rlen     = re - rb;
  assign k1       = GW'(cfg.open_half_width) + GW'(1);
  assign k2       = GW'({cfg.open_half_width, 1'b0}) + GW'(1);
  assign gap      = rb - pending_end;

  always_comb begin
    if (at_left && at_right) begin
      keep = 1'b1;
    end else if (at_left || at_right) begin
      keep = rlen >= k1;
    end else begin
      keep = rlen >= k2;
    end
  end

  assign merge = pending_valid && (rb >= pending_end) && (gap < cfg.merge_gap_limit);

  always_comb begin
    emit_a = 1'b0;
    pv2    = pending_valid;
    ps2    = pending_start;
    pe2    = pending_end;
    if (close && keep) begin
      if (merge) begin
        pe2 = re;
      end else begin
        emit_a = pending_valid;
        pv2    = 1'b1;
        ps2    = rb;
        pe2    = re;
      end
    end
    emit_b = eol && (forced || pv2);
  end

  always_comb begin
    res_a.line_index = line_counter;
    res_a.seg_start  = pending_start[rrse_pkg::START_W-1:0];
    res_a.seg_end    = pending_end;
    res_a.last       = !emit_b;
    res_b.line_index = line_counter;
    res_b.seg_start  = forced ? '0 : ps2[rrse_pkg::START_W-1:0];
    res_b.seg_end    = forced ? len_u : pe2;
    res_b.last       = 1'b1;
    if (forced) begin
      push.valid0 = process && eol;
      push.valid1 = 1'b0;
      push.r0     = res_b;
    end else begin
      push.valid0 = process && (emit_a || emit_b);
      push.valid1 = process && emit_a && emit_b;
      push.r0     = emit_a ? res_a : res_b;
    end
    push.r1 = res_b;
  end

  always_comb begin
    in_run_next        = px_bit && !eol && !forced;
    run_begin_next     = (px_bit && !in_run) ? column_count : run_begin;
    pending_valid_next = pv2 && !eol && !forced;
    pending_start_next = ps2;
    pending_end_next   = pe2;
    if (eol) begin
      column_count_next = '0;
      line_counter_next = last_line ? '0 : line_counter + 1'b1;
    end else begin
      column_count_next = column_count + GW'(1);
      line_counter_next = line_counter;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      px_valid      <= 1'b0;
      column_count  <= '0;
      line_counter  <= '0;
      in_run        <= 1'b0;
      run_begin     <= '0;
      pending_valid <= 1'b0;
      pending_start <= '0;
      pending_end   <= '0;
    end else begin
      if (in_valid && !in_stall) begin
        px_valid <= 1'b1;
        px_bit   <= edge_bit;
      end else if (process) begin
        px_valid <= 1'b0;
      end
      if (process) begin
        column_count  <= column_count_next;
        line_counter  <= line_counter_next;
        in_run        <= in_run_next;
        run_begin     <= run_begin_next;
        pending_valid <= pending_valid_next;
        pending_start <= pending_start_next;
        pending_end   <= pending_end_next;
      end
    end
  end

endmodule

@@ sv/rrse_result_fifo.sv @@
// ----------------------------------------------------------------------------
// rrse_result_fifo
// Small result queue taking up to two segments per cycle, releasing one while out_stall is low.
// ----------------------------------------------------------------------------
module rrse_result_fifo (
  input  logic                         clk,
  input  logic                         rst,
  input  rrse_pkg::push_t              push,
  output logic                         room,
  output logic                         out_valid,
  input  logic                         out_stall,
  output rrse_pkg::result_t            head
);

  localparam int PW = rrse_pkg::QPTR_W;
  localparam int CW = rrse_pkg::QCNT_W;

  rrse_pkg::result_t mem [rrse_pkg::QDEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count, count_next;
  logic          pop;
  logic [CW-1:0] n_push;

  assign out_valid = (count != '0);
  assign head      = mem[rd_ptr];
  assign pop       = out_valid && !out_stall;
  // Keep space for a two-segment line end
  assign room      = count <= CW'(rrse_pkg::QDEPTH - 2);
  assign n_push    = CW'(push.valid0) + CW'(push.valid1);
  assign count_next = count + n_push - CW'(pop);

  always_ff @(posedge clk) begin
    if (push.valid0) begin
      mem[wr_ptr] <= push.r0;
    end
    if (push.valid1) begin
      mem[wr_ptr + PW'(1)] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + n_push[PW-1:0];
      if (pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      count <= count_next;
    end
  end

endmodule

@@ sv/row_run_segment_extractor_unit.sv @@
// ----------------------------------------------------------------------------
// row_run_segment_extractor_unit
// Binary edge pixels in, opened and merged horizontal segments out.
// ----------------------------------------------------------------------------
// One pixel is taken per clock while in_stall is low. A pixel passes an input
// register and, once the queue has room, is folded into the line state; any
// segments it completes land in a four-entry result queue. A line end can
// complete two segments, which leave the queue one per cycle while the output
// is not held off; the input stalls only while the queue holds more than two
// segments, so lines of two or more pixels keep the full pixel rate when the
// output is not held off. Config writes are taken every cycle and act at
// once; write them only between frames or while the block is drained.
module row_run_segment_extractor_unit #(
  parameter int MAX_LINE_LENGTH = rrse_pkg::MAX_LINE_LENGTH_DEF,
  parameter int MAX_LINES       = rrse_pkg::MAX_LINES_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rrse_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rrse_pkg::GEO_W-1:0]          cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                edge_bit,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [rrse_pkg::LINE_W-1:0]         line_index,
  output logic [rrse_pkg::START_W-1:0]        seg_start,
  output logic [rrse_pkg::END_W-1:0]          seg_end,
  output logic                                last
);

  rrse_pkg::cfg_t    cfg;
  rrse_pkg::push_t   push;
  rrse_pkg::result_t head;
  logic              room;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.open_half_width <= rrse_pkg::OPEN_HALF_WIDTH_RST;
      cfg.merge_gap_limit <= rrse_pkg::MERGE_GAP_LIMIT_RST;
      cfg.line_length     <= rrse_pkg::LINE_LENGTH_RST;
      cfg.line_count      <= rrse_pkg::LINE_COUNT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (rrse_pkg::reg_index_t'(cfg_index))
        rrse_pkg::REG_OPEN_HALF_WIDTH: begin
          cfg.open_half_width <= cfg_data[rrse_pkg::K_W-1:0];
        end
        rrse_pkg::REG_MERGE_GAP_LIMIT: cfg.merge_gap_limit <= cfg_data;
        rrse_pkg::REG_LINE_LENGTH:     cfg.line_length     <= cfg_data;
        rrse_pkg::REG_LINE_COUNT:      cfg.line_count      <= cfg_data;
        default: ;
      endcase
    end
  end

  rrse_core #(
    .MAX_LINE_LENGTH (MAX_LINE_LENGTH),
    .MAX_LINES       (MAX_LINES)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (in_valid),
    .edge_bit (edge_bit),
    .in_stall (in_stall),
    .room     (room),
    .push     (push)
  );

  rrse_result_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .head      (head)
  );

  assign line_index = head.line_index;
  assign seg_start  = head.seg_start;
  assign seg_end    = head.seg_end;
  assign last       = head.last;

endmodule
